// ===== hw/rtl/cslex_pkg.sv =====
// Package for the C subset lexer: token kinds, character codes, keyword
// table and the result item type shared by the core, the queue and the top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cslex_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned CH_W            = 8;
  localparam int unsigned KIND_W          = 5;
  localparam int unsigned POS_W           = 16;
  localparam int unsigned NUM_W           = 63;
  localparam int unsigned PREFIX_W        = 48;
  localparam int unsigned TDATA_W         = 104;
  localparam int unsigned OUTQ_DEPTH      = 4;
  localparam int unsigned NUM_KW          = 8;

  // tdata bit positions of the result fields
  localparam int unsigned PUNCT_LSB = 0;
  localparam int unsigned START_LSB = 8;
  localparam int unsigned LEN_LSB   = 24;
  localparam int unsigned VALUE_LSB = 40;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_NUM    = 5'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd1;
  localparam logic [KIND_W-1:0] KIND_SIZEOF = 5'd2;
  localparam logic [KIND_W-1:0] KIND_EQ     = 5'd10;
  localparam logic [KIND_W-1:0] KIND_NE     = 5'd11;
  localparam logic [KIND_W-1:0] KIND_GE     = 5'd12;
  localparam logic [KIND_W-1:0] KIND_LE     = 5'd13;
  localparam logic [KIND_W-1:0] KIND_GT     = 5'd14;
  localparam logic [KIND_W-1:0] KIND_LT     = 5'd15;
  localparam logic [KIND_W-1:0] KIND_PUNCT  = 5'd16;
  localparam logic [KIND_W-1:0] KIND_EOF    = 5'd17;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd18;

  localparam logic [CH_W-1:0] CH_EQ   = 8'h3D;
  localparam logic [CH_W-1:0] CH_BANG = 8'h21;
  localparam logic [CH_W-1:0] CH_LT   = 8'h3C;
  localparam logic [CH_W-1:0] CH_GT   = 8'h3E;
  localparam logic [CH_W-1:0] CH_ZERO = 8'h30;

  // sizeof for int while if else goto return, right aligned
  localparam logic [PREFIX_W-1:0] KW_TEXT [NUM_KW] = '{
    48'h73697A656F66, 48'h000000666F72, 48'h000000696E74, 48'h007768696C65,
    48'h000000006966, 48'h0000656C7365, 48'h0000676F746F, 48'h72657475726E
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd6, 3'd3, 3'd3, 3'd5, 3'd2, 3'd4, 3'd4, 3'd6
  };

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   punct;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
    logic [NUM_W-1:0]  value;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cslex_core.sv =====
// Lexer state and per-item step logic: classifies one character per step
// and pushes up to two result items. Depends on cslex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cslex_core #(
  parameter int unsigned OFFSET_BITS = cslex_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic [cslex_pkg::CH_W-1:0] ch_i,
  input  wire logic                       eot_i,
  output cslex_pkg::push_t                push_o
);

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_WORD = 5'b00010,
    MODE_NUM  = 5'b00100,
    MODE_OP   = 5'b01000,
    MODE_ERR  = 5'b10000
  } mode_e;

  mode_e                               mode_q, mode_d;
  logic [cslex_pkg::PREFIX_W-1:0]      prefix_q, prefix_d;
  logic [OFFSET_BITS-1:0]              run_q, run_d;
  logic [OFFSET_BITS-1:0]              start_q, start_d;
  logic [OFFSET_BITS-1:0]              pos_q, pos_d;
  logic [cslex_pkg::NUM_W-1:0]         acc_q, acc_d;
  logic [cslex_pkg::CH_W-1:0]          pend_q, pend_d;

  logic                                is_alpha, is_digit, is_space, is_punct, is_op;
  logic [cslex_pkg::KIND_W-1:0]        word_kind;
  logic [cslex_pkg::NUM_W+3:0]         acc_wide;
  logic [cslex_pkg::NUM_W-1:0]         acc_next;
  logic [3:0]                          digit;

  logic                                flush_v, flush_err;
  cslex_pkg::result_t                  flush_r;
  logic                                cls_v;
  mode_e                               cls_mode;
  cslex_pkg::result_t                  cls_r;
  logic                                v_a, v_b, use_cls;
  cslex_pkg::result_t                  r_a, r_b;

  assign is_alpha = (ch_i >= 8'h61 && ch_i <= 8'h7A) || (ch_i >= 8'h41 && ch_i <= 8'h5A) ||
                    (ch_i == 8'h5F);
  assign is_digit = (ch_i >= 8'h30 && ch_i <= 8'h39);
  assign is_space = (ch_i == 8'h20) || (ch_i >= 8'h09 && ch_i <= 8'h0D);
  assign is_op    = (ch_i == cslex_pkg::CH_EQ) || (ch_i == cslex_pkg::CH_BANG) ||
                    (ch_i == cslex_pkg::CH_LT) || (ch_i == cslex_pkg::CH_GT);
  assign is_punct = (ch_i == 8'h2B) || (ch_i == 8'h2D) || (ch_i == 8'h2A) ||
                    (ch_i == 8'h2F) || (ch_i == 8'h25) || (ch_i == 8'h28) ||
                    (ch_i == 8'h29) || (ch_i == 8'h3B) || (ch_i == 8'h3D) ||
                    (ch_i == 8'h7B) || (ch_i == 8'h7D) || (ch_i == 8'h3A) ||
                    (ch_i == 8'h2C) || (ch_i == 8'h26);

  assign digit = 4'(ch_i - cslex_pkg::CH_ZERO);

  // acc * 10 + digit, saturated
  assign acc_wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
                    (cslex_pkg::NUM_W + 4)'(digit);
  assign acc_next = (acc_wide > (cslex_pkg::NUM_W + 4)'(cslex_pkg::NUM_MAX)) ?
                    cslex_pkg::NUM_MAX : acc_wide[cslex_pkg::NUM_W-1:0];

  always_comb begin
    word_kind = cslex_pkg::KIND_IDENT;
    for (int i = cslex_pkg::NUM_KW - 1; i >= 0; i--) begin
      if (run_q == OFFSET_BITS'(cslex_pkg::KW_LEN[i]) && prefix_q == cslex_pkg::KW_TEXT[i]) begin
        word_kind = cslex_pkg::KIND_SIZEOF + cslex_pkg::KIND_W'(i);
      end
    end
  end

  always_comb begin
    flush_v   = 1'b0;
    flush_err = 1'b0;
    flush_r   = '0;
    flush_r.start = 16'(start_q);
    unique case (mode_q)
      MODE_WORD: begin
        flush_v      = 1'b1;
        flush_r.kind = word_kind;
        flush_r.len  = 16'(run_q);
      end
      MODE_NUM: begin
        flush_v       = 1'b1;
        flush_r.kind  = cslex_pkg::KIND_NUM;
        flush_r.len   = 16'(run_q);
        flush_r.value = acc_q;
      end
      MODE_OP: begin
        flush_v     = 1'b1;
        flush_r.len = 16'd1;
        case (pend_q)
          cslex_pkg::CH_GT: flush_r.kind = cslex_pkg::KIND_GT;
          cslex_pkg::CH_LT: flush_r.kind = cslex_pkg::KIND_LT;
          cslex_pkg::CH_EQ: begin
            flush_r.kind  = cslex_pkg::KIND_PUNCT;
            flush_r.punct = cslex_pkg::CH_EQ;
          end
          default: begin
            flush_r.kind = cslex_pkg::KIND_ERROR;
            flush_err    = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    cls_v     = 1'b0;
    cls_mode  = MODE_IDLE;
    cls_r     = '0;
    cls_r.start = 16'(pos_q);
    cls_r.len   = 16'd1;
    if (is_space) begin
      cls_mode = MODE_IDLE;
    end else if (is_alpha) begin
      cls_mode = MODE_WORD;
    end else if (is_digit) begin
      cls_mode = MODE_NUM;
    end else if (is_op) begin
      cls_mode = MODE_OP;
    end else if (is_punct) begin
      cls_v       = 1'b1;
      cls_r.kind  = cslex_pkg::KIND_PUNCT;
      cls_r.punct = ch_i;
    end else begin
      cls_v      = 1'b1;
      cls_r.kind = cslex_pkg::KIND_ERROR;
      cls_mode   = MODE_ERR;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    prefix_d = prefix_q;
    run_d    = run_q;
    start_d  = start_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    pend_d   = pend_q;
    v_a      = 1'b0;
    v_b      = 1'b0;
    r_a      = flush_r;
    r_b      = cls_r;
    use_cls  = 1'b0;
    if (eot_i) begin
      v_a      = flush_v;
      v_b      = 1'b1;
      r_b      = '0;
      r_b.kind = cslex_pkg::KIND_EOF;
      r_b.start = 16'(pos_q);
      mode_d   = MODE_IDLE;
      prefix_d = '0;
      run_d    = '0;
      start_d  = '0;
      pos_d    = '0;
      acc_d    = '0;
      pend_d   = '0;
    end else begin
      pos_d = pos_q + 1'b1;
      unique case (mode_q)
        MODE_ERR: ;
        MODE_WORD: begin
          if (is_alpha || is_digit) begin
            if (run_q < OFFSET_BITS'(6)) begin
              prefix_d = {prefix_q[cslex_pkg::PREFIX_W-9:0], ch_i};
            end
            if (run_q != '1) begin
              run_d = run_q + 1'b1;
            end
          end else begin
            v_a     = 1'b1;
            use_cls = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit) begin
            acc_d = acc_next;
            if (run_q != '1) begin
              run_d = run_q + 1'b1;
            end
          end else begin
            v_a     = 1'b1;
            use_cls = 1'b1;
          end
        end
        MODE_OP: begin
          v_a    = 1'b1;
          pend_d = '0;
          if (ch_i == cslex_pkg::CH_EQ) begin
            r_a       = '0;
            r_a.start = 16'(start_q);
            r_a.len   = 16'd2;
            case (pend_q)
              cslex_pkg::CH_EQ:   r_a.kind = cslex_pkg::KIND_EQ;
              cslex_pkg::CH_BANG: r_a.kind = cslex_pkg::KIND_NE;
              cslex_pkg::CH_GT:   r_a.kind = cslex_pkg::KIND_GE;
              default:            r_a.kind = cslex_pkg::KIND_LE;
            endcase
            mode_d = MODE_IDLE;
          end else if (flush_err) begin
            mode_d = MODE_ERR;
          end else begin
            use_cls = 1'b1;
          end
        end
        default: use_cls = 1'b1;
      endcase
      if (use_cls) begin
        v_b    = cls_v;
        mode_d = cls_mode;
        if (cls_mode == MODE_WORD) begin
          start_d  = pos_q;
          prefix_d = cslex_pkg::PREFIX_W'(ch_i);
          run_d    = OFFSET_BITS'(1);
        end else if (cls_mode == MODE_NUM) begin
          start_d = pos_q;
          acc_d   = cslex_pkg::NUM_W'(digit);
          run_d   = OFFSET_BITS'(1);
        end else if (cls_mode == MODE_OP) begin
          start_d = pos_q;
          pend_d  = ch_i;
        end
      end
    end
  end

  always_comb begin
    push_o           = '0;
    push_o.res0      = v_a ? r_a : r_b;
    push_o.res0.last = !(v_a && v_b);
    push_o.res1      = r_b;
    push_o.res1.last = 1'b1;
    if (step_i) begin
      push_o.cnt = {1'b0, v_a} + {1'b0, v_b};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      prefix_q <= '0;
      run_q    <= '0;
      start_q  <= '0;
      pos_q    <= '0;
      acc_q    <= '0;
      pend_q   <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      prefix_q <= prefix_d;
      run_q    <= run_d;
      start_q  <= start_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      pend_q   <= pend_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cslex_outq.sv =====
// Result queue of the lexer: takes up to two result items a cycle and
// hands them out one at a time. Depends on cslex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cslex_outq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cslex_pkg::push_t push_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output cslex_pkg::result_t    data_o
);

  localparam int unsigned PTR_W = $clog2(cslex_pkg::OUTQ_DEPTH);

  cslex_pkg::result_t   mem_q [cslex_pkg::OUTQ_DEPTH];
  logic [PTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]       cnt_q, cnt_d;
  logic                 pop;
  logic [PTR_W-1:0]     wr_next;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign room_o  = (cnt_q <= (PTR_W + 1)'(cslex_pkg::OUTQ_DEPTH - 2));
  assign pop     = valid_o && ready_i;
  assign wr_next = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + PTR_W'(push_i.cnt);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PTR_W + 1)'(push_i.cnt) - (PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/c_subset_lexer_unit.sv =====
// C subset lexer: one source character per item in, token items out.
// Depends on cslex_pkg, cslex_core and cslex_outq.
//
// Input channel s_axis: tdata is the character, tuser set marks the end of
// text (no character; pending token is flushed, then EOF is sent and the
// lexer returns to its reset state for a new text).
// Output channel m_axis: one token per item; tuser is the token kind, tdata
// the other fields; tlast marks the final token caused by one input item.
// An input item causes zero, one or two tokens.
// The first token of an item passes the input register, then the lexer
// step into the result queue; a second token follows as soon as the first
// is taken. Throughput: one input item per cycle as long as each item
// causes at most one token and the receiver keeps m_axis_tready high;
// items causing two tokens slow the input. The four-entry result queue
// sets this: a step runs only while two entries are free.
// Reset clears the lexer to idle between tokens, offset zero, and empties
// the queue. When the receiver stalls, tokens wait in the queue and then
// s_axis_tready drops; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module c_subset_lexer_unit #(
  parameter int unsigned OFFSET_BITS = cslex_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [cslex_pkg::CH_W-1:0]      s_axis_tdata,  // ch[7:0]
  input  wire logic                            s_axis_tuser,  // end_of_text
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // punct_char[7:0], start_offset[23:8], token_length[39:24],
  // number_value[102:40], zero[103]
  output logic [cslex_pkg::TDATA_W-1:0]        m_axis_tdata,
  output logic [cslex_pkg::KIND_W-1:0]         m_axis_tuser,  // kind[4:0]
  output logic                                 m_axis_tlast
);

  logic                          in_valid_q, in_valid_d;
  logic [cslex_pkg::CH_W-1:0]    in_ch_q;
  logic                          in_eot_q;
  logic                          room, step;
  cslex_pkg::push_t              push;
  cslex_pkg::result_t            res;

  assign step          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || step;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q  <= s_axis_tdata;
      in_eot_q <= s_axis_tuser;
    end
  end

  cslex_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ch_i   (in_ch_q),
    .eot_i  (in_eot_q),
    .push_o (push)
  );

  cslex_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res)
  );

  assign m_axis_tdata = {1'b0, res.value, res.len, res.start, res.punct};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== hw/rtl/cslex_checker.sv =====
// Port-level checks on the lexer's output channel, bound to the top level.
// Depends on cslex_pkg and c_subset_lexer_unit.
`timescale 1ns / 1ps
`default_nettype none

module cslex_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [cslex_pkg::TDATA_W-1:0] m_axis_tdata,
  input wire logic [cslex_pkg::KIND_W-1:0]  m_axis_tuser,
  input wire logic                          m_axis_tlast
);

  logic [cslex_pkg::KIND_W-1:0] kind;
  logic [cslex_pkg::CH_W-1:0]   punct;
  logic [15:0]                  len;

  assign kind  = m_axis_tuser;
  assign punct = m_axis_tdata[cslex_pkg::PUNCT_LSB +: cslex_pkg::CH_W];
  assign len   = m_axis_tdata[cslex_pkg::LEN_LSB +: cslex_pkg::POS_W];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind == cslex_pkg::KIND_EOF |-> m_axis_tlast && len == 16'd0)
    else $error("EOF item without tlast or with nonzero length");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> kind <= cslex_pkg::KIND_ERROR)
    else $error("token kind out of range");

  a_punct_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind != cslex_pkg::KIND_PUNCT |-> punct == 8'd0)
    else $error("punctuation byte on a non-punct token");

  a_op_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == cslex_pkg::KIND_EQ || kind == cslex_pkg::KIND_NE ||
      kind == cslex_pkg::KIND_GE || kind == cslex_pkg::KIND_LE) |-> len == 16'd2)
    else $error("two-character operator with wrong length");

endmodule

bind c_subset_lexer_unit cslex_checker u_cslex_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
